### rtl/core/nlms_predictor_bank_exp_aggregation_core_assert.svh
// ---------------------------------------------------------------------------
// NLMS predictor bank assertion macros
// Concurrent assertion wrappers shared by the RTL files of the core. They
// compile to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef NLMS_PREDICTOR_BANK_EXP_AGGREGATION_CORE_ASSERT_SVH
`define NLMS_PREDICTOR_BANK_EXP_AGGREGATION_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define NPBEA_ASSERT_IMP(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication.
`define NPBEA_ASSERT_NXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define NPBEA_ASSERT_IMP(lbl, clk, rst, pre, post)
`define NPBEA_ASSERT_NXT(lbl, clk, rst, pre, post)
`endif

`endif

### rtl/core/npbea_pkg.sv
// ---------------------------------------------------------------------------
// NLMS predictor bank package
// Shared widths, configuration indexes, sequencer states, divider interface
// types and the coefficient set of the exp approximation.
// ---------------------------------------------------------------------------
package npbea_pkg;

  // Shared multiplier operand and product widths.
  localparam int MUL_AW = 44;
  localparam int MUL_BW = 18;
  localparam int MUL_PW = 62;

  // Shared divider widths: numerator, denominator, quotient, step counter.
  localparam int DIV_NW = 62;
  localparam int DIV_DW = 48;
  localparam int DIV_QW = 36;
  localparam int DIV_CW = 6;

  // Highest coefficient index of the 2^-u Horner polynomial, evaluated from there down.
  localparam logic [2:0] EXP_TOP = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LOSS_STRATEGY = 3'd0;
  localparam logic [2:0] CFG_LEARNING_RATE = 3'd1;
  localparam logic [2:0] CFG_STEP_SIZE_0   = 3'd2;
  localparam logic [2:0] CFG_STEP_SIZE_1   = 3'd3;
  localparam logic [2:0] CFG_STEP_SIZE_2   = 3'd4;
  localparam logic [2:0] CFG_STEP_SIZE_3   = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOSS_A,
    ST_LOSS_B,
    ST_MIN,
    ST_EXP_Z,
    ST_EXP_H,
    ST_EXP_W,
    ST_WDIV,
    ST_F_ACC,
    ST_F_MUS,
    ST_F_MUE,
    ST_F_DIV,
    ST_F_UPD,
    ST_SHIFT,
    ST_P_ACC,
    ST_P_AGG,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_QW-1:0] quot;
  } div_rsp_t;

  // Q30 coefficients of the alternating Horner polynomial for 2^-u.
  function automatic logic [30:0] exp_coef(input logic [2:0] n);
    logic [30:0] c;
    case (n)
      3'd0:    c = 31'd1073741824;
      3'd1:    c = 31'd744261118;
      3'd2:    c = 31'd257941248;
      3'd3:    c = 31'd59597083;
      3'd4:    c = 31'd10327388;
      3'd5:    c = 31'd1431680;
      3'd6:    c = 31'd165394;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/npbea_mul.sv
// ---------------------------------------------------------------------------
// NLMS predictor bank shared multiplier
// Signed multiplier with a registered product, reused for every product of
// the sequencer.
// ---------------------------------------------------------------------------
module npbea_mul (
  input  logic                                clk,
  input  logic signed [npbea_pkg::MUL_AW-1:0] a,
  input  logic signed [npbea_pkg::MUL_BW-1:0] b,
  output logic signed [npbea_pkg::MUL_PW-1:0] p
);
  import npbea_pkg::*;

  // The product is available in the cycle after the operands.
  always_ff @(posedge clk) begin
    p <= MUL_PW'(a * b);
  end

endmodule

### rtl/core/npbea_div.sv
// ---------------------------------------------------------------------------
// NLMS predictor bank shared divider
// Unsigned restoring divider, one quotient bit per cycle. The numerator must
// be below the denominator times two to the quotient width.
// ---------------------------------------------------------------------------
`include "nlms_predictor_bank_exp_aggregation_core_assert.svh"

module npbea_div (
  input  logic                clk,
  input  logic                rst,
  input  npbea_pkg::div_req_t req,
  output npbea_pkg::div_rsp_t rsp
);
  import npbea_pkg::*;

  localparam int RW = DIV_DW + 1;

  logic [RW-1:0]     rem;
  logic [DIV_QW-1:0] nlo;
  logic [DIV_QW-1:0] quo;
  logic [DIV_DW-1:0] den;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic              done;
  logic [RW-1:0]     trial;
  logic              fits;

  // Trial subtraction of the denominator from the shifted remainder.
  assign trial = {rem[DIV_DW-1:0], nlo[DIV_QW-1]};
  assign fits  = trial >= {1'b0, den};

  // Control: busy for one step per quotient bit, then a done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= RW'(req.num[DIV_NW-1:DIV_QW]);
      nlo <= req.num[DIV_QW-1:0];
      den <= req.den;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? (trial - {1'b0, den}) : trial;
      nlo <= {nlo[DIV_QW-2:0], 1'b0};
      quo <= {quo[DIV_QW-2:0], fits};
    end
  end

  assign rsp = '{busy: busy, done: done, quot: quo};

  `NPBEA_ASSERT_IMP(a_start_idle, clk, rst, req.start, !busy)
  `NPBEA_ASSERT_NXT(a_start_busy, clk, rst, req.start, busy)
  `NPBEA_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)

endmodule

### rtl/core/nlms_predictor_bank_exp_aggregation_core.sv
// ---------------------------------------------------------------------------
// NLMS predictor bank with exponentially weighted aggregation
// A start item goes from idle to the done state, which loads its result once
// the output is free. Other items run loss, exp, weight division, filter update,
// shift and prediction steps, no weight division if every weight vanishes. The
// next item is taken in the cycle after the result loads, also while it waits.
// Reset loads the register defaults, clears the series and sets weights 1/N.
// ---------------------------------------------------------------------------
`include "nlms_predictor_bank_exp_aggregation_core_assert.svh"

module nlms_predictor_bank_exp_aggregation_core #(
  parameter int NUM_PREDICTORS = 4,
  parameter int FILTER_ORDER   = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [15:0] sample_value,
  input  logic               series_start,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [15:0] aggregate_prediction,
  output logic signed [15:0] prediction_0,
  output logic signed [15:0] prediction_1,
  output logic signed [15:0] prediction_2,
  output logic signed [15:0] prediction_3,
  output logic        [15:0] weight_0,
  output logic        [15:0] weight_1,
  output logic        [15:0] weight_2,
  output logic        [15:0] weight_3,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [15:0] cfg_data
);
  import npbea_pkg::*;

  localparam int NP   = NUM_PREDICTORS;
  localparam int FO   = FILTER_ORDER;
  localparam int PI_W = (NP > 1) ? $clog2(NP) : 1;
  localparam int TJ_W = (FO > 1) ? $clog2(FO) : 1;
  localparam logic [15:0] W_UNI = 16'((32768 + NP / 2) / NP);

  // Configuration registers.
  logic        loss_strategy;
  logic [15:0] learning_rate;
  logic [15:0] step_size [4];

  // Series state.
  logic signed [15:0] hist   [FO];
  logic signed [23:0] coef   [NP][FO];
  logic        [15:0] weight [NP];
  logic signed [15:0] pred   [NP];
  logic signed [15:0] agg;

  // Sequencer.
  state_t            state;
  state_t            state_next;
  logic [1:0]        ph;
  logic [PI_W-1:0]   pi;
  logic [TJ_W-1:0]   tj;
  logic [2:0]        hn;
  logic              pi_last;
  logic              tj_last;
  logic              out_free;

  // Working registers.
  logic signed [15:0] x_reg;
  logic signed [49:0] loss [NP];
  logic signed [49:0] lmin;
  logic signed [33:0] t_reg;
  logic        [45:0] w_prod [NP];
  logic        [47:0] s_sum;
  logic        [30:0] r_reg;
  logic        [15:0] u_reg;
  logic        [4:0]  k_reg;
  logic               e_zero;
  logic signed [43:0] acc;
  logic        [34:0] sq_sum;
  logic        [35:0] den_r;
  logic signed [43:0] err_r;
  logic               num_neg;
  logic [DIV_NW-1:0]  num_mag;
  logic signed [37:0] q_r;

  // Shared units.
  logic signed [MUL_AW-1:0] op_a;
  logic signed [MUL_BW-1:0] op_b;
  logic signed [MUL_PW-1:0] prod;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // Helper values.
  logic signed [15:0] pred_sel;
  logic        [15:0] wt_sel;
  logic signed [15:0] hist_sel;
  logic signed [23:0] coef_sel;
  logic        [15:0] mu_sel;
  logic signed [16:0] d_loss;
  logic signed [49:0] lmin_c;
  logic        [50:0] delta;
  logic        [30:0] y_val;
  logic               y_big;
  logic        [48:0] zsum;
  logic        [30:0] e_val;
  logic        [51:0] den_tmp;
  logic signed [MUL_PW-1:0] upd;
  logic signed [39:0] csum;
  logic signed [43:0] accn;
  logic        [37:0] q_mag;
  logic signed [15:0] pred_pad [4];
  logic        [15:0] wt_pad   [4];

  // Rounding to nearest, halves away from zero, by 2^15.
  function automatic logic signed [MUL_PW-1:0] rnd15(input logic signed [MUL_PW-1:0] v);
    logic signed [MUL_PW-1:0] half;
    half = MUL_PW'(16384);
    if (v >= 0) begin
      return (v + half) >>> 15;
    end
    return -((-v + half) >>> 15);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [MUL_PW-1:0] v);
    if (v > MUL_PW'(8388607)) begin
      return 24'sh7FFFFF;
    end
    if (v < -MUL_PW'(8388608)) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [MUL_PW-1:0] v);
    if (v > MUL_PW'(32767)) begin
      return 16'sh7FFF;
    end
    if (v < -MUL_PW'(32768)) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  npbea_mul u_mul (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .p   (prod)
  );

  npbea_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Element selection at the current predictor and tap.
  assign pred_sel = pred[pi];
  assign wt_sel   = weight[pi];
  assign hist_sel = hist[tj];
  assign coef_sel = coef[pi][tj];
  assign mu_sel   = step_size[2'(pi)];
  assign pi_last  = (pi == PI_W'(NP - 1));
  assign tj_last  = (tj == TJ_W'(FO - 1));
  assign out_free = !result_valid || !result_stall;
  assign cfg_ready = 1'b1;

  // Loss difference, minimum loss, exp argument and the update and sum terms.
  always_comb begin
    d_loss = loss_strategy ? (17'(agg) - 17'(x_reg)) : (17'(pred_sel) - 17'(x_reg));
    lmin_c = loss[0];
    for (int i = 1; i < NP; i++) begin
      if (loss[i] < lmin_c) begin
        lmin_c = loss[i];
      end
    end
    delta   = 51'(loss[pi]) - 51'(lmin);
    y_val   = delta[50:20];
    y_big   = y_val > 31'd4194304;
    zsum    = {1'b0, prod[47:0]} + 49'd32768;
    e_val   = e_zero ? '0 : (r_reg >> k_reg);
    den_tmp = {1'b0, prod[50:0]} + 52'd16384;
    upd     = rnd15(prod);
    csum    = 40'(coef_sel) + signed'(upd[39:0]);
    accn    = acc + signed'(prod[43:0]);
    q_mag   = 38'(div_rsp.quot);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = series_start ? ST_DONE : ST_LOSS_A;
        end
      end
      ST_LOSS_A: if (ph[0]) state_next = ST_LOSS_B;
      ST_LOSS_B: if (ph[0]) state_next = pi_last ? ST_MIN : ST_LOSS_A;
      ST_MIN:    state_next = ST_EXP_Z;
      ST_EXP_Z:  if (ph[0]) state_next = ST_EXP_H;
      ST_EXP_H:  if (ph[0] && hn == 3'd0) state_next = ST_EXP_W;
      ST_EXP_W:  if (ph[0]) state_next = pi_last ? ST_WDIV : ST_EXP_Z;
      ST_WDIV: begin
        if (ph == 2'd0 && s_sum == '0) begin
          state_next = ST_F_ACC;
        end else if (ph[0] && div_rsp.done && pi_last) begin
          state_next = ST_F_ACC;
        end
      end
      ST_F_ACC:  if (ph == 2'd2 && tj_last) state_next = ST_F_MUS;
      ST_F_MUS:  if (ph[0]) state_next = ST_F_MUE;
      ST_F_MUE:  if (ph[0]) state_next = ST_F_DIV;
      ST_F_DIV:  if (ph[0] && div_rsp.done) state_next = ST_F_UPD;
      ST_F_UPD: begin
        if (ph[0] && tj_last) begin
          state_next = pi_last ? ST_SHIFT : ST_F_ACC;
        end
      end
      ST_SHIFT:  state_next = ST_P_ACC;
      ST_P_ACC:  if (ph[0] && tj_last && pi_last) state_next = ST_P_AGG;
      ST_P_AGG:  if (ph[0] && pi_last) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Shared unit operands and handshake outputs.
  always_comb begin
    sample_stall = (state != ST_IDLE);
    op_a         = '0;
    op_b         = '0;
    div_req      = '{start: 1'b0, num: '0, den: '0};
    case (state)
      ST_LOSS_A: begin
        op_a = MUL_AW'(learning_rate);
        op_b = MUL_BW'(d_loss);
      end
      ST_LOSS_B: begin
        op_a = MUL_AW'(t_reg);
        op_b = loss_strategy ? MUL_BW'(pred_sel) : MUL_BW'(d_loss);
      end
      ST_EXP_Z: begin
        op_a = MUL_AW'(y_val);
        op_b = 18'sd94548;
      end
      ST_EXP_H: begin
        op_a = MUL_AW'(r_reg);
        op_b = MUL_BW'(u_reg);
      end
      ST_EXP_W: begin
        op_a = MUL_AW'(e_val);
        op_b = MUL_BW'(wt_sel);
      end
      ST_WDIV: begin
        div_req.start = (ph == 2'd0) && (s_sum != '0);
        div_req.num   = DIV_NW'({w_prod[pi], 15'd0}) + DIV_NW'(s_sum >> 1);
        div_req.den   = s_sum;
      end
      ST_F_ACC: begin
        op_a = (ph == 2'd0) ? MUL_AW'(coef_sel) : MUL_AW'(hist_sel);
        op_b = MUL_BW'(hist_sel);
      end
      ST_F_MUS: begin
        op_a = MUL_AW'(sq_sum);
        op_b = MUL_BW'(mu_sel);
      end
      ST_F_MUE: begin
        op_a = err_r;
        op_b = MUL_BW'(mu_sel);
      end
      ST_F_DIV: begin
        div_req.start = (ph == 2'd0);
        div_req.num   = num_mag;
        div_req.den   = DIV_DW'(den_r);
      end
      ST_F_UPD: begin
        op_a = MUL_AW'(q_r);
        op_b = MUL_BW'(hist_sel);
      end
      ST_P_ACC: begin
        op_a = MUL_AW'(coef_sel);
        op_b = MUL_BW'(hist_sel);
      end
      ST_P_AGG: begin
        op_a = MUL_AW'(pred_sel);
        op_b = MUL_BW'(wt_sel);
      end
      default: begin
      end
    endcase
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_strategy <= 1'b0;
      learning_rate <= 16'd4096;
      step_size[0]  <= 16'd3277;
      step_size[1]  <= 16'd6554;
      step_size[2]  <= 16'd13107;
      step_size[3]  <= 16'd26214;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOSS_STRATEGY: loss_strategy <= cfg_data[0];
        CFG_LEARNING_RATE: learning_rate <= cfg_data;
        CFG_STEP_SIZE_0:   step_size[0]  <= cfg_data;
        CFG_STEP_SIZE_1:   step_size[1]  <= cfg_data;
        CFG_STEP_SIZE_2:   step_size[2]  <= cfg_data;
        CFG_STEP_SIZE_3:   step_size[3]  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer counters, series state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ph           <= '0;
      pi           <= '0;
      tj           <= '0;
      hn           <= '0;
      result_valid <= 1'b0;
      agg          <= '0;
      for (int i = 0; i < FO; i++) begin
        hist[i] <= '0;
      end
      for (int i = 0; i < NP; i++) begin
        weight[i] <= W_UNI;
        pred[i]   <= '0;
        for (int j = 0; j < FO; j++) begin
          coef[i][j] <= '0;
        end
      end
    end else begin
      state <= state_next;
      // Result valid rises as the result register loads and falls once taken.
      if (state == ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          ph <= '0;
          pi <= '0;
          tj <= '0;
          if (sample_valid && series_start) begin
            agg <= '0;
            for (int i = 1; i < FO; i++) begin
              hist[i] <= '0;
            end
            hist[0] <= sample_value;
            for (int i = 0; i < NP; i++) begin
              weight[i] <= W_UNI;
              pred[i]   <= '0;
              for (int j = 0; j < FO; j++) begin
                coef[i][j] <= '0;
              end
            end
          end
        end
        ST_LOSS_A, ST_EXP_Z, ST_F_MUS, ST_F_MUE: begin
          ph <= ph[0] ? 2'd0 : 2'd1;
          if (state == ST_EXP_Z && ph[0]) begin
            hn <= EXP_TOP - 3'd1;
          end
        end
        ST_LOSS_B, ST_EXP_W: begin
          ph <= ph[0] ? 2'd0 : 2'd1;
          if (ph[0]) begin
            pi <= pi_last ? '0 : pi + 1'b1;
          end
        end
        ST_EXP_H: begin
          ph <= ph[0] ? 2'd0 : 2'd1;
          if (ph[0] && hn != 3'd0) begin
            hn <= hn - 3'd1;
          end
        end
        ST_WDIV: begin
          if (ph == 2'd0) begin
            if (s_sum == '0) begin
              for (int i = 0; i < NP; i++) begin
                weight[i] <= W_UNI;
              end
              pi <= '0;
              tj <= '0;
            end else begin
              ph <= 2'd1;
            end
          end else if (div_rsp.done) begin
            weight[pi] <= div_rsp.quot[15:0];
            ph         <= 2'd0;
            pi         <= pi_last ? '0 : pi + 1'b1;
            tj         <= '0;
          end
        end
        ST_F_ACC: begin
          if (ph == 2'd2) begin
            ph <= 2'd0;
            tj <= tj_last ? '0 : tj + 1'b1;
          end else begin
            ph <= ph + 2'd1;
          end
        end
        ST_F_DIV: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else if (div_rsp.done) begin
            ph <= 2'd0;
            tj <= '0;
          end
        end
        ST_F_UPD: begin
          ph <= ph[0] ? 2'd0 : 2'd1;
          if (ph[0]) begin
            coef[pi][tj] <= sat24(MUL_PW'(csum));
            tj           <= tj_last ? '0 : tj + 1'b1;
            if (tj_last) begin
              pi <= pi_last ? '0 : pi + 1'b1;
            end
          end
        end
        ST_SHIFT: begin
          for (int j = 1; j < FO; j++) begin
            hist[j] <= hist[j-1];
          end
          hist[0] <= x_reg;
          pi      <= '0;
          tj      <= '0;
          ph      <= '0;
        end
        ST_P_ACC: begin
          ph <= ph[0] ? 2'd0 : 2'd1;
          if (ph[0]) begin
            tj <= tj_last ? '0 : tj + 1'b1;
            if (tj_last) begin
              pred[pi] <= sat16(rnd15(MUL_PW'(accn)));
              pi       <= pi_last ? '0 : pi + 1'b1;
            end
          end
        end
        ST_P_AGG: begin
          ph <= ph[0] ? 2'd0 : 2'd1;
          if (ph[0]) begin
            pi <= pi_last ? '0 : pi + 1'b1;
            if (pi_last) begin
              agg <= sat16(rnd15(MUL_PW'(accn)));
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of the loss, exp, division and filter steps.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          x_reg <= sample_value;
        end
      end
      ST_LOSS_A: begin
        if (ph[0]) begin
          t_reg <= prod[33:0];
        end
      end
      ST_LOSS_B: begin
        if (ph[0]) begin
          loss[pi] <= loss_strategy ? {prod[48:0], 1'b0} : prod[49:0];
        end
      end
      ST_MIN: begin
        lmin  <= lmin_c;
        s_sum <= '0;
      end
      ST_EXP_Z: begin
        if (ph[0]) begin
          u_reg  <= zsum[31:16];
          k_reg  <= zsum[36:32];
          e_zero <= y_big || (zsum[48:32] > 17'd30);
          r_reg  <= exp_coef(EXP_TOP);
        end
      end
      ST_EXP_H: begin
        if (ph[0]) begin
          r_reg <= exp_coef(hn) - prod[46:16];
        end
      end
      ST_EXP_W: begin
        if (ph[0]) begin
          w_prod[pi] <= prod[45:0];
          s_sum      <= s_sum + 48'(prod[45:0]);
        end
      end
      ST_WDIV: begin
        acc    <= '0;
        sq_sum <= '0;
      end
      ST_F_ACC: begin
        if (ph == 2'd1) begin
          acc <= accn;
        end else if (ph == 2'd2) begin
          sq_sum <= sq_sum + 35'(prod[30:0]);
        end
      end
      ST_F_MUS: begin
        if (ph[0]) begin
          den_r <= 36'(37'h1000000 + den_tmp[51:15]);
          err_r <= (44'(x_reg) <<< 15) - acc;
        end
      end
      ST_F_MUE: begin
        if (ph[0]) begin
          num_neg <= prod[MUL_PW-1];
          num_mag <= prod[MUL_PW-1] ? DIV_NW'(-prod) : DIV_NW'(prod);
        end
      end
      ST_F_DIV: begin
        if (div_rsp.done) begin
          q_r <= num_neg ? -signed'(q_mag) : signed'(q_mag);
        end
      end
      ST_F_UPD: begin
        acc    <= '0;
        sq_sum <= '0;
      end
      ST_SHIFT: begin
        acc <= '0;
      end
      ST_P_ACC, ST_P_AGG: begin
        if (ph[0]) begin
          if (state == ST_P_ACC) begin
            acc <= tj_last ? '0 : accn;
          end else begin
            acc <= pi_last ? '0 : accn;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Unused predictor slots read as zero.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pred_pad[i] = '0;
      wt_pad[i]   = '0;
    end
    for (int i = 0; i < NP; i++) begin
      pred_pad[i] = pred[i];
      wt_pad[i]   = weight[i];
    end
  end

  // Result register, loaded when the previous transaction has left.
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      aggregate_prediction <= agg;
      prediction_0         <= pred_pad[0];
      prediction_1         <= pred_pad[1];
      prediction_2         <= pred_pad[2];
      prediction_3         <= pred_pad[3];
      weight_0             <= wt_pad[0];
      weight_1             <= wt_pad[1];
      weight_2             <= wt_pad[2];
      weight_3             <= wt_pad[3];
    end
  end

  `NPBEA_ASSERT_NXT(a_accept_busy, clk, rst, sample_valid && !sample_stall, sample_stall)
  `NPBEA_ASSERT_IMP(a_upd_div_idle, clk, rst, state == ST_F_UPD, !div_rsp.busy)
  `NPBEA_ASSERT_NXT(a_done_loads, clk, rst, state == ST_DONE && out_free,
                    result_valid && !sample_stall)

endmodule

### test/tb.sv
// ---------------------------------------------------------------------------
// NLMS predictor bank aggregation core testbench
// Drives sample transactions through the core, predicts every result with a
// fixed-point model of the filter bank and weight update, and compares each
// result transaction field by field under several idle and stall phases.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import npbea_pkg::*;

  localparam int NP = 4;
  localparam int NO = 4;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 1100;

  typedef struct packed {
    logic signed [15:0] agg;
    logic signed [15:0] p0, p1, p2, p3;
    logic [15:0] w0, w1, w2, w3;
  } forecast_t;

  typedef struct {
    logic signed [15:0] value;
    logic               start;
    logic               known;
    forecast_t          want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [15:0] sample_value = '0;
  logic series_start = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [15:0] aggregate_prediction, prediction_0, prediction_1;
  logic signed [15:0] prediction_2, prediction_3;
  logic [15:0] weight_0, weight_1, weight_2, weight_3;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #4 clk = ~clk;

  nlms_predictor_bank_exp_aggregation_core dut (.*);

  // Model state of the filter bank.
  logic        m_loss_grad;
  longint      m_eta;
  longint      m_mu [NP];
  longint      m_hist [NO];
  longint      m_coef [NP][NO];
  longint      m_wt [NP];
  longint      m_pred [NP];
  longint      m_agg;

  forecast_t   pending_forecasts [$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  function automatic longint round_shift(longint v, int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Fixed-point 2^-z approximation of exp(-y).
  function automatic longint exp_decay(longint unsigned y);
    longint unsigned z, k, u, r;
    longint unsigned coef [7];
    coef = '{64'd1073741824, 64'd744261118, 64'd257941248, 64'd59597083,
             64'd10327388, 64'd1431680, 64'd165394};
    if (y > (64'd1 << 22)) return 0;
    z = (y * 94548 + 32768) >> 16;
    k = z >> 16;
    if (k > 30) return 0;
    u = z & 16'hFFFF;
    r = coef[6];
    for (int n = 5; n >= 0; n--) r = coef[n] - ((r * u) >> 16);
    return longint'(r >> k);
  endfunction

  function automatic void clear_series();
    for (int i = 0; i < NP; i++) begin
      m_pred[i] = 0;
      m_wt[i] = (32768 + NP / 2) / NP;
      for (int j = 0; j < NO; j++) m_coef[i][j] = 0;
    end
    for (int j = 0; j < NO; j++) m_hist[j] = 0;
    m_agg = 0;
  endfunction

  task automatic apply_register(int idx, int val);
    case (idx)
      CFG_LOSS_STRATEGY: m_loss_grad = val[0];
      CFG_LEARNING_RATE: m_eta = val & 16'hFFFF;
      CFG_STEP_SIZE_0, CFG_STEP_SIZE_1, CFG_STEP_SIZE_2, CFG_STEP_SIZE_3:
        m_mu[idx - CFG_STEP_SIZE_0] = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  // Advance the model by one sample and return the expected forecast.
  function automatic forecast_t forecast_next(longint x, logic start);
    forecast_t f;
    longint loss [NP];
    longint unsigned w [NP];
    longint unsigned s, sq;
    longint lmin, acc, err, den, q, c, agg;
    if (start) begin
      clear_series();
      m_hist[0] = x;
    end else begin
      // Exponential weight update.
      for (int i = 0; i < NP; i++)
        loss[i] = m_loss_grad ? 2 * m_eta * (m_agg - x) * m_pred[i]
                              : m_eta * (m_pred[i] - x) * (m_pred[i] - x);
      lmin = loss[0];
      for (int i = 1; i < NP; i++) if (loss[i] < lmin) lmin = loss[i];
      s = 0;
      for (int i = 0; i < NP; i++) begin
        w[i] = longint'(m_wt[i]) * exp_decay(longint'(loss[i] - lmin) >> 20);
        s += w[i];
      end
      if (s == 0) begin
        for (int i = 0; i < NP; i++) m_wt[i] = (32768 + NP / 2) / NP;
      end else begin
        for (int i = 0; i < NP; i++) m_wt[i] = (w[i] * 32768 + s / 2) / s;
      end
      // NLMS coefficient update.
      for (int i = 0; i < NP; i++) begin
        acc = 0;
        sq = 0;
        for (int j = 0; j < NO; j++) begin
          acc += m_hist[j] * m_coef[i][j];
          sq += m_hist[j] * m_hist[j];
        end
        err = x * 32768 - acc;
        den = (longint'(1) << 24) + longint'((m_mu[i] * sq + 16384) >> 15);
        q = (m_mu[i] * err) / den;
        for (int j = 0; j < NO; j++) begin
          c = m_coef[i][j] + round_shift(q * m_hist[j], 15);
          m_coef[i][j] = clamp(c, -8388608, 8388607);
        end
      end
      for (int j = NO - 1; j > 0; j--) m_hist[j] = m_hist[j - 1];
      m_hist[0] = x;
      agg = 0;
      for (int i = 0; i < NP; i++) begin
        acc = 0;
        for (int j = 0; j < NO; j++) acc += m_hist[j] * m_coef[i][j];
        m_pred[i] = clamp(round_shift(acc, 15), -32768, 32767);
        agg += m_wt[i] * m_pred[i];
      end
      m_agg = clamp(round_shift(agg, 15), -32768, 32767);
    end
    f.agg = m_agg[15:0];
    f.p0 = m_pred[0][15:0]; f.p1 = m_pred[1][15:0];
    f.p2 = m_pred[2][15:0]; f.p3 = m_pred[3][15:0];
    f.w0 = m_wt[0][15:0]; f.w1 = m_wt[1][15:0];
    f.w2 = m_wt[2][15:0]; f.w3 = m_wt[3][15:0];
    return f;
  endfunction

  // Receiver stall, redrawn every cycle.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Result checking and watchdog.
  always @(posedge clk) begin
    forecast_t got, want;
    if (!rst) begin
      if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Regression FAIL");
        $finish;
      end
      if (result_valid && !result_stall) begin
        got = '{aggregate_prediction, prediction_0, prediction_1, prediction_2,
                prediction_3, weight_0, weight_1, weight_2, weight_3};
        if (pending_forecasts.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, got);
          fail_count++;
        end else begin
          want = pending_forecasts.pop_front();
          if (got.agg !== want.agg) begin
            $display("%0t: aggregate exp %0d got %0d", $time, want.agg, got.agg);
            fail_count++;
          end
          if ({got.p0, got.p1, got.p2, got.p3} !== {want.p0, want.p1, want.p2, want.p3})
          begin
            $display("%0t: predictions exp %0d %0d %0d %0d got %0d %0d %0d %0d", $time,
                     want.p0, want.p1, want.p2, want.p3, got.p0, got.p1, got.p2, got.p3);
            fail_count++;
          end
          if ({got.w0, got.w1, got.w2, got.w3} !== {want.w0, want.w1, want.w2, want.w3})
          begin
            $display("%0t: weights exp %0d %0d %0d %0d got %0d %0d %0d %0d", $time,
                     want.w0, want.w1, want.w2, want.w3, got.w0, got.w1, got.w2, got.w3);
            fail_count++;
          end
        end
      end
    end
  end

  // Valid is left high after the write; the next sample transaction drops it.
  task automatic write_register(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, val);
  endtask

  // Hold the sender idle until every result is in.
  task automatic wait_empty();
    sample_valid <= 1'b0;
    while (pending_forecasts.size() != 0) @(posedge clk);
  endtask

  // Wait until every result is in, then let the block settle.
  task automatic drain();
    wait_empty();
    repeat (600) @(posedge clk);
  endtask

  task automatic send_sample(logic signed [15:0] v, logic st, logic known,
                             forecast_t want);
    forecast_t f;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    f = forecast_next(longint'(v), st);
    if (known && f !== want) begin
      $display("%0t: table row exp %h model %h", $time, want, f);
      fail_count++;
    end
    pending_forecasts.push_back(f);
    sample_valid <= 1'b1;
    sample_value <= v;
    series_start <= st;
    do @(posedge clk); while (sample_stall);
  endtask

  function automatic logic signed [15:0] random_sample(int level);
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom);
      default: return $signed(16'($urandom_range(2 * level))) - 16'(level);
    endcase
  endfunction

  task automatic random_phase(int count, int amp);
    logic signed [15:0] phase;
    for (int n = 0; n < count; n++) begin
      phase = 16'($urandom_range(65535));
      send_sample(($urandom_range(99) < 70) ? 16'(longint'(amp) *
                  ((n * 7 + phase) % 64 - 32) / 32) : random_sample(amp),
                  $urandom_range(39) == 0, 1'b0, '0);
    end
  endtask

  localparam forecast_t UNIFORM = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                    16'd8192, 16'd8192, 16'd8192, 16'd8192};

  initial begin
    stim_row_t rows [$];
    m_loss_grad = 1'b0;
    m_eta = 4096;
    m_mu = '{3277, 6554, 13107, 26214};
    clear_series();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: starts give uniform weights and zero forecasts.
    rows = '{
      '{16'sd0, 1'b0, 1'b1, UNIFORM},
      '{16'sh7FFF, 1'b1, 1'b1, UNIFORM},
      '{16'sh7FFF, 1'b0, 1'b0, '0},
      '{16'sh8000, 1'b0, 1'b0, '0},
      '{16'sh7FFF, 1'b0, 1'b0, '0},
      '{16'sh8000, 1'b1, 1'b1, UNIFORM},
      '{16'sh8000, 1'b0, 1'b0, '0},
      '{16'sh8000, 1'b0, 1'b0, '0},
      '{16'sd4096, 1'b0, 1'b0, '0},
      '{-16'sd4096, 1'b0, 1'b0, '0},
      '{16'sd1, 1'b0, 1'b0, '0},
      '{-16'sd1, 1'b0, 1'b0, '0},
      '{16'sd0, 1'b1, 1'b1, UNIFORM},
      '{16'sd0, 1'b0, 1'b1, UNIFORM},
      '{16'sd2048, 1'b0, 1'b0, '0},
      '{16'sd2048, 1'b0, 1'b0, '0}
    };
    foreach (rows[r]) send_sample(rows[r].value, rows[r].start, rows[r].known,
                                  rows[r].want);
    drain();
    write_register(CFG_LOSS_STRATEGY, 16'd1);
    write_register(CFG_LEARNING_RATE, 16'hFFFF);
    write_register(CFG_STEP_SIZE_0, 16'hFFFF);
    write_register(CFG_STEP_SIZE_3, 16'd0);
    foreach (rows[r]) if (r >= 2 && r < 12) send_sample(rows[r].value, 1'b0, 1'b0, '0);

    // Random phases across settings and idle patterns.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_register(CFG_LOSS_STRATEGY, 16'(ph & 1));
      write_register(CFG_LEARNING_RATE, ph == 2 ? 16'd0 : ph == 5 ? 16'hFFFF :
                     16'($urandom_range(16384)));
      write_register(CFG_STEP_SIZE_0, ph == 3 ? 16'hFFFF : 16'($urandom));
      write_register(CFG_STEP_SIZE_1, ph == 3 ? 16'd0 : 16'($urandom_range(32768)));
      write_register(CFG_STEP_SIZE_2, 16'($urandom_range(40000)));
      write_register(CFG_STEP_SIZE_3, ph == 6 ? 16'hFFFF : 16'($urandom_range(32768)));
      write_register(3'd7, 16'($urandom));
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      send_sample(random_sample(8192), 1'b1, 1'b0, '0);
      random_phase(N_RANDOM / 16, 1 << (10 + ph % 5));
      // Hold off until the block has returned everything.
      wait_empty();
      random_phase(N_RANDOM / 16, 1 << (10 + ph % 5));
    end

    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
